[hw/rtl/dbwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbwd_pkg: shared types and constants of the dictionary bitmask decompressor
// Command, format and status codes, field and stream widths, flip patterns
// and the default dictionary depth.
// ----------------------------------------------------------------------------
package dbwd_pkg;

    // default number of dictionary entries
    localparam int DICT_DEPTH_DEF = 16;

    // field widths
    localparam int WORD_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int FMT_W    = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    // stream widths, tdata padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // item kind
    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    // compressed word formats
    typedef enum logic [FMT_W-1:0]
    {
        FMT_RAW     = 3'd0,
        FMT_RLE     = 3'd1,
        FMT_BITMASK = 3'd2,
        FMT_RUN1    = 3'd3,
        FMT_RUN2    = 3'd4,
        FMT_RUN4    = 3'd5,
        FMT_TWO_BIT = 3'd6,
        FMT_DIRECT  = 3'd7
    } fmt_t;

    // result status
    typedef enum logic [STATUS_W-1:0]
    {
        ST_DECODED = 2'd0,
        ST_WRITTEN = 2'd1,
        ST_RLE     = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    // top-aligned flip patterns
    localparam logic [WORD_W-1:0] PAT_RUN1 = 32'h8000_0000;
    localparam logic [WORD_W-1:0] PAT_RUN2 = 32'hC000_0000;
    localparam logic [WORD_W-1:0] PAT_RUN4 = 32'hF000_0000;

endpackage

[hw/rtl/dictionary_bitmask_word_decompressor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dictionary_bitmask_word_decompressor_core: bitmask code decompressor
// Restores 32-bit instruction words from a small dictionary of words that is
// loaded through the same input stream.
//
// Usage:
//   input stream  s_*: one word per item; tuser carries the command (write
//     or decode) and the format, tdata the dictionary slot and the payload
//   output stream m_*: one result per input item, in order; tdata holds the
//     restored word, tuser the status (decoded, entry written, rle rejected)
//   throughput: one item per cycle until an m_tready stall fills the pipeline;
//     the dictionary write and read share the second stage, so a decode
//     right after a write sees the new entry
//   a three-stage pipeline (input register, dictionary read and mask
//     shift, xor into the output register) sets the latency
//   stall: when m_tready is low the output holds; earlier stages keep filling
//     until all three are full, then s_tready drops; nothing is lost
//   reset: clears all valid bits and sets every dictionary entry to zero
// ----------------------------------------------------------------------------
module dictionary_bitmask_word_decompressor_core
#(
    parameter int DICT_DEPTH = dbwd_pkg::DICT_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dict_slot [3:0], payload [35:4], zero pad [39:36]
    input  logic [dbwd_pkg::S_TDATA_W-1:0] s_tdata,
    // command [0], format_code [3:1]
    input  logic [dbwd_pkg::S_TUSER_W-1:0] s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // word [31:0]
    output logic [dbwd_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [dbwd_pkg::M_TUSER_W-1:0] m_tuser
);

    import dbwd_pkg::*;

    localparam int IDX_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam logic [SLOT_W:0] DEPTH_L = (SLOT_W+1)'(DICT_DEPTH);

    // stage 1: input register
    logic              v1_reg;
    cmd_t              cmd1_reg;
    logic [SLOT_W-1:0] slot1_reg;
    fmt_t              fmt1_reg;
    logic [WORD_W-1:0] pay1_reg;

    // stage 2: base word and flip mask
    logic              v2_reg;
    logic [WORD_W-1:0] base2_reg;
    logic [WORD_W-1:0] flip2_reg;
    status_t           st2_reg;
    logic [WORD_W-1:0] base2_next;
    logic [WORD_W-1:0] flip2_next;
    status_t           st2_next;

    // stage 3: output register
    logic              v3_reg;
    logic [WORD_W-1:0] word3_reg;
    status_t           st3_reg;

    // dictionary
    logic [WORD_W-1:0] dict_reg [DICT_DEPTH];

    logic adv1;
    logic adv2;
    logic adv3;

    // stall chain
    assign adv3     = !v3_reg || m_tready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s_tvalid)
        begin
            cmd1_reg  <= cmd_t'(s_tuser[0]);
            fmt1_reg  <= fmt_t'(s_tuser[3:1]);
            slot1_reg <= s_tdata[SLOT_W-1:0];
            pay1_reg  <= s_tdata[SLOT_W+WORD_W-1:SLOT_W];
        end
    end

    // dictionary read and flip mask build
    logic [SLOT_W-1:0] rd_slot;
    logic [WORD_W-1:0] entry;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
    logic [POS_W-1:0]  pos_c;
    logic [WORD_W-1:0] bm_pat;

    assign rd_slot = pay1_reg[SLOT_W-1:0];
    assign entry   = ({1'b0, rd_slot} < DEPTH_L) ? dict_reg[rd_slot[IDX_W-1:0]] : '0;
    assign pos_a   = pay1_reg[12:8];
    assign pos_b   = pay1_reg[8:4];
    assign pos_c   = pay1_reg[13:9];
    assign bm_pat  = {pay1_reg[7:4], {(WORD_W-4){1'b0}}};

    always_comb
    begin
        base2_next = '0;
        flip2_next = '0;
        st2_next   = ST_DECODED;
        if (cmd1_reg == CMD_WRITE)
        begin
            st2_next = ST_WRITTEN;
        end
        else
        begin
            unique case (fmt1_reg)
                FMT_RAW:
                begin
                    base2_next = pay1_reg;
                end
                FMT_RLE:
                begin
                    st2_next = ST_RLE;
                end
                FMT_BITMASK:
                begin
                    base2_next = entry;
                    flip2_next = bm_pat >> pos_a;
                end
                FMT_RUN1:
                begin
                    base2_next = entry;
                    flip2_next = PAT_RUN1 >> pos_b;
                end
                FMT_RUN2:
                begin
                    base2_next = entry;
                    flip2_next = PAT_RUN2 >> pos_b;
                end
                FMT_RUN4:
                begin
                    base2_next = entry;
                    flip2_next = PAT_RUN4 >> pos_b;
                end
                FMT_TWO_BIT:
                begin
                    base2_next = entry;
                    flip2_next = (PAT_RUN1 >> pos_c) | (PAT_RUN1 >> pos_b);
                end
                FMT_DIRECT:
                begin
                    base2_next = entry;
                end
                default:
                begin
                    base2_next = '0;
                end
            endcase
        end
    end

    // dictionary write, in order with the reads of stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DICT_DEPTH; i++)
            begin
                dict_reg[i] <= '0;
            end
        end
        else if (v1_reg && adv2 && cmd1_reg == CMD_WRITE && {1'b0, slot1_reg} < DEPTH_L)
        begin
            dict_reg[slot1_reg[IDX_W-1:0]] <= pay1_reg;
        end
    end

    // stage 2 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            base2_reg <= base2_next;
            flip2_reg <= flip2_next;
            st2_reg   <= st2_next;
        end
    end

    // stage 3: apply flips into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            word3_reg <= base2_reg ^ flip2_reg;
            st3_reg   <= st2_reg;
        end
    end

    // output stream
    assign m_tvalid = v3_reg;
    assign m_tdata  = word3_reg;
    assign m_tuser  = st3_reg;

endmodule

[dv/tb_dictionary_bitmask_word_decompressor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dictionary_bitmask_word_decompressor_core: self-checking bench
// Streams dictionary writes and compressed decode words into the core and
// checks every restored word and status against an in-bench dictionary
// model. Directed corner words come first, then random traffic with random
// gaps on both sides, one long output stall and two full drain pauses.
// ----------------------------------------------------------------------------
module tb_dictionary_bitmask_word_decompressor_core;

    import dbwd_pkg::*;

    localparam int DEPTH       = DICT_DEPTH_DEF;
    localparam int N_RANDOM    = 1030;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 64;

    // one input word as the bench sees it
    typedef struct {
        cmd_t                cmd;
        logic [SLOT_W-1:0]   slot;
        fmt_t                fmt;
        logic [WORD_W-1:0]   payload;
        bit                  drain_first;
    } dec_item_t;

    // one expected result word
    typedef struct {
        logic [WORD_W-1:0] word;
        status_t           status;
    } restored_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    dec_item_t         pending_items[$];
    restored_t         restored_q[$];
    logic [WORD_W-1:0] dict_model [DEPTH];

    dec_item_t cur_item;
    int        sent_count = 0;
    int        total_items = 0;
    int        fail_count = 0;
    int        rx_count = 0;
    int        results_seen = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    logic      rx_holding = 1'b0;
    int        stall_cycles = 0;
    int        n_writes = 0;
    int        fmt_hits [8];

    dictionary_bitmask_word_decompressor_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // dictionary model update and expected result for one accepted word
    function automatic void predict_restore(input dec_item_t it);
        restored_t         r;
        logic [WORD_W-1:0] base;
        r.word   = '0;
        r.status = ST_DECODED;
        base     = (it.payload[3:0] < DEPTH) ? dict_model[it.payload[3:0]] : '0;
        if (it.cmd == CMD_WRITE)
        begin
            if (it.slot < DEPTH)
                dict_model[it.slot] = it.payload;
            r.status = ST_WRITTEN;
        end
        else
        begin
            case (it.fmt)
                FMT_RAW:     r.word = it.payload;
                FMT_RLE:     r.status = ST_RLE;
                // mask extends toward the lsb from the named bit
                FMT_BITMASK: r.word = base ^ ({it.payload[7:4], 28'h0} >> it.payload[12:8]);
                FMT_RUN1:    r.word = base ^ (PAT_RUN1 >> it.payload[8:4]);
                FMT_RUN2:    r.word = base ^ (PAT_RUN2 >> it.payload[8:4]);
                FMT_RUN4:    r.word = base ^ (PAT_RUN4 >> it.payload[8:4]);
                // equal positions flip the bit once
                FMT_TWO_BIT: r.word = base ^ ((PAT_RUN1 >> it.payload[13:9]) |
                                              (PAT_RUN1 >> it.payload[8:4]));
                default:     r.word = base;
            endcase
        end
        restored_q = {restored_q, r};
    endfunction

    function automatic void add_write(input logic [SLOT_W-1:0] slot,
                                      input logic [WORD_W-1:0] data);
        dec_item_t it;
        it.cmd         = CMD_WRITE;
        it.slot        = slot;
        it.fmt         = fmt_t'($urandom_range(0, 7));
        it.payload     = data;
        it.drain_first = 1'b0;
        pending_items  = {pending_items, it};
        n_writes++;
    endfunction

    function automatic void add_decode(input fmt_t fmt, input logic [WORD_W-1:0] payload,
                                       input bit drain_first);
        dec_item_t it;
        it.cmd         = CMD_DECODE;
        it.slot        = SLOT_W'($urandom_range(0, 15));
        it.fmt         = fmt;
        it.payload     = payload;
        it.drain_first = drain_first;
        pending_items  = {pending_items, it};
        fmt_hits[fmt]++;
    endfunction

    // driver: offers queued words, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_restore(cur_item);
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 &&
                    (rx_holding || (sent_count >= 500 && sent_count < 700) ||
                     $urandom_range(0, 99) >= 25) &&
                    (!pending_items[0].drain_first || results_seen == sent_count))
                begin
                    cur_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'h0, cur_item.payload, cur_item.slot};
                    s_tuser  <= {cur_item.fmt, cur_item.cmd};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word, drives ready with gaps and one long hold
    always @(posedge clk or negedge rst_n)
    begin
        restored_t exp_r;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            rx_holding <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (restored_q.size() == 0)
                begin
                    $error("unexpected result: word %h, status %0d", m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    exp_r = restored_q.pop_front();
                    if (m_tdata !== exp_r.word)
                    begin
                        $error("word mismatch: expected %h, actual %h", exp_r.word, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== exp_r.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_r.status, m_tuser);
                        fail_count++;
                    end
                end
                rx_count++;
            end
            results_seen <= rx_count;
            // one long hold so the pipeline fills and back-pressures the input
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && rx_count >= 300)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            m_tready   <= (hold_left == 0) &&
                          ((rx_count >= 500 && rx_count < 700) || $urandom_range(0, 99) >= 25);
            rx_holding <= (hold_left > 0);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_dictionary_bitmask_word_decompressor_core failed");
                $finish;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [WORD_W-1:0] pl;
        fmt_t              f;
        for (int i = 0; i < DEPTH; i++)
            dict_model[i] = '0;
        for (int i = 0; i < 8; i++)
            fmt_hits[i] = 0;

        // directed corners: cleared dictionary, extremes, near-lsb drops
        add_decode(FMT_DIRECT, {28'h0, 4'd5}, 1'b0);
        add_write(4'd0, 32'hFFFF_FFFF);
        add_write(4'd15, 32'hA5A5_3C3C);
        add_write(4'd7, 32'h0000_0000);
        add_decode(FMT_RAW, 32'hFFFF_FFFF, 1'b0);
        add_decode(FMT_RAW, 32'h0000_0000, 1'b0);
        add_decode(FMT_RLE, $urandom(), 1'b0);
        add_decode(FMT_BITMASK, {19'h0, 5'd0, 4'hF, 4'd0}, 1'b0);
        add_decode(FMT_BITMASK, {19'h7FFFF, 5'd31, 4'hF, 4'd15}, 1'b0);
        add_decode(FMT_BITMASK, {19'h0, 5'd30, 4'h9, 4'd7}, 1'b0);
        add_decode(FMT_RUN1, {23'h0, 5'd0, 4'd15}, 1'b0);
        add_decode(FMT_RUN1, {23'h7FFFFF, 5'd31, 4'd0}, 1'b0);
        add_decode(FMT_RUN2, {23'h0, 5'd31, 4'd7}, 1'b0);
        add_decode(FMT_RUN4, {23'h0, 5'd29, 4'd15}, 1'b0);
        add_decode(FMT_RUN4, {23'h0, 5'd0, 4'd0}, 1'b0);
        add_decode(FMT_TWO_BIT, {18'h0, 5'd12, 5'd12, 4'd15}, 1'b0);
        add_decode(FMT_TWO_BIT, {18'h3FFFF, 5'd0, 5'd31, 4'd7}, 1'b0);
        add_decode(FMT_DIRECT, {28'hFFF_FFFF, 4'd15}, 1'b0);
        // decode right behind a write must see the new entry
        add_write(4'd15, 32'h1234_5678);
        add_decode(FMT_DIRECT, {28'h0, 4'd15}, 1'b0);
        add_decode(FMT_RUN2, {23'h0, 5'd16, 4'd15}, 1'b0);

        // random traffic, some positions pushed to the lsb end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n != 400 && n != 900 && $urandom_range(0, 99) < 20)
                add_write(SLOT_W'($urandom_range(0, 15)), $urandom());
            else
            begin
                f  = fmt_t'($urandom_range(0, 7));
                pl = $urandom();
                if ($urandom_range(0, 9) == 0)
                begin
                    if (f == FMT_BITMASK)
                        pl[12:8] = POS_W'($urandom_range(28, 31));
                    else
                        pl[8:4] = POS_W'($urandom_range(28, 31));
                end
                add_decode(f, pl, (n == 400 || n == 900));
            end
        end
        total_items = pending_items.size();

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_items.size() > 0 || s_tvalid || results_seen != total_items);
        // catch stray results after the last expected one
        repeat (10) @(posedge clk);
        if (restored_q.size() != 0)
        begin
            $error("%0d expected results never arrived", restored_q.size());
            fail_count++;
        end

        $display("run covered %0d words: %0d dictionary writes and %0d decodes over all formats",
                 total_items, n_writes, total_items - n_writes);
        $display("with random gaps, a %0d-cycle output hold and two full drain pauses",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("tb_dictionary_bitmask_word_decompressor_core passed");
        else
            $display("tb_dictionary_bitmask_word_decompressor_core failed");
        $finish;
    end

endmodule
